// ===== src/pta_pkg.sv =====
// Package for the prior-table probability adjuster: command and status codes,
// field widths, default sizes and the item metadata types. No dependencies.
package pta_pkg;

  localparam int PRIOR_ENTRIES_DEF = 4096;
  localparam int DIMENSIONS_DEF    = 4;
  localparam int CLASSES_DEF       = 8;

  localparam int FEAT_W = 16;
  localparam int SPAN_W = 13;
  localparam int OFF_W  = 13;
  localparam int PROB_W = 16;
  localparam int ODDS_W = 24;
  localparam int DEN_W  = 59;
  localparam int REM_W  = 60;
  localparam int QUO_W  = 17;
  localparam int NDIM   = 4;

  localparam logic [1:0] CMD_PRIOR_WR = 2'd0;
  localparam logic [1:0] CMD_ODDS_WR  = 2'd1;
  localparam logic [1:0] CMD_ADJUST   = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_INDEX    = 2'd2;
  localparam logic [1:0] ST_ZERO_DEN = 2'd3;

  localparam logic [2:0] REG_DIM0_MIN  = 3'd0;
  localparam logic [2:0] REG_DIM1_MIN  = 3'd1;
  localparam logic [2:0] REG_DIM2_MIN  = 3'd2;
  localparam logic [2:0] REG_DIM3_MIN  = 3'd3;
  localparam logic [2:0] REG_DIM0_SPAN = 3'd4;
  localparam logic [2:0] REG_DIM1_SPAN = 3'd5;
  localparam logic [2:0] REG_DIM2_SPAN = 3'd6;
  localparam logic [2:0] REG_DIM3_SPAN = 3'd7;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [2:0]        slot;
    logic [11:0]       eidx;
    logic [23:0]       word;
    logic [PROB_W-1:0] p;
  } meta_t;

  typedef struct packed {
    logic [1:0] status;
    logic       zero_out;
  } div_meta_t;

endpackage

// ===== src/pta_if.sv =====
// Item channel interfaces of the prior-table adjuster (input and result).
// Plain valid/ready handshake; no package dependency.
interface pta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] feature_0;
  logic [15:0] feature_1;
  logic [15:0] feature_2;
  logic [15:0] feature_3;
  logic [15:0] prediction;
  logic [2:0]  class_slot;
  logic [11:0] entry_index;
  logic [23:0] entry_word;

  modport source (output valid, cmd, feature_0, feature_1, feature_2, feature_3,
                  prediction, class_slot, entry_index, entry_word, input ready);
  modport sink   (input valid, cmd, feature_0, feature_1, feature_2, feature_3,
                  prediction, class_slot, entry_index, entry_word, output ready);
endinterface

interface pta_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] adjusted;
  logic [1:0]  status;

  modport source (output valid, adjusted, status, input ready);
  modport sink   (input valid, adjusted, status, output ready);
endinterface

// ===== src/pta_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module pta_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pta_index.sv =====
// Range check and mixed-radix index pipeline: one check stage, then three
// Horner multiply-add stages. Depends on pta_pkg.
module pta_index import pta_pkg::*; #(
  parameter int PRIOR_ENTRIES = PRIOR_ENTRIES_DEF,
  parameter int DIMENSIONS    = DIMENSIONS_DEF,
  parameter int IW            = $clog2(PRIOR_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  meta_t                       in_meta,
  input  logic [NDIM-1:0][FEAT_W-1:0] feat,
  input  logic [NDIM-1:0][FEAT_W-1:0] dmin,
  input  logic [NDIM-1:0][SPAN_W-1:0] dspan,
  output logic                        out_valid,
  output meta_t                       out_meta,
  output logic [IW-1:0]               out_idx,
  output logic                        out_range_bad,
  output logic                        out_big
);

  localparam int TW = (IW > OFF_W) ? IW : OFF_W;
  localparam int SW = TW + SPAN_W + 1;
  localparam int HS = NDIM - 1;

  // stage 0 is the check stage, stages 1..HS fold in one dimension each
  logic                        v_r    [HS+1];
  meta_t                       meta_r [HS+1];
  logic [NDIM-1:0][OFF_W-1:0]  off_r  [HS+1];
  logic [NDIM-1:0][SPAN_W-1:0] span_r [HS+1];
  logic [TW-1:0]               t_r    [HS+1];
  logic                        big_r  [HS+1];
  logic                        bad_r  [HS+1];

  logic [NDIM-1:0][OFF_W-1:0]  off_c;
  logic [NDIM-1:0][SPAN_W-1:0] span_c;
  logic                        bad_c;
  logic [16:0]                 diff;

  always_comb begin
    bad_c = 1'b0;
    diff  = '0;
    for (int d = 0; d < NDIM; d++) begin
      diff = {feat[d][FEAT_W-1], feat[d]} - {dmin[d][FEAT_W-1], dmin[d]};
      if (d < DIMENSIONS) begin
        off_c[d]  = diff[OFF_W-1:0];
        span_c[d] = dspan[d];
        if (diff[16] || (diff[15:0] >= {3'b000, dspan[d]})) begin
          bad_c = 1'b1;
        end
      end else begin
        off_c[d]  = '0;
        span_c[d] = SPAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
    if (adv) begin
      meta_r[0] <= in_meta;
      off_r[0]  <= off_c;
      span_r[0] <= span_c;
      bad_r[0]  <= bad_c;
      t_r[0]    <= TW'(off_c[NDIM-1]);
      big_r[0]  <= (SW'(off_c[NDIM-1]) >= SW'(PRIOR_ENTRIES));
    end
  end

  for (genvar k = 0; k < HS; k++) begin : g_horner
    localparam int D = NDIM - 2 - k;
    logic [SW-1:0] sum;
    assign sum = SW'(off_r[k][D]) + SW'(span_r[k][D]) * SW'(t_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
      if (adv) begin
        meta_r[k+1] <= meta_r[k];
        off_r[k+1]  <= off_r[k];
        span_r[k+1] <= span_r[k];
        bad_r[k+1]  <= bad_r[k];
        t_r[k+1]    <= TW'(sum);
        big_r[k+1]  <= big_r[k] | (sum >= SW'(PRIOR_ENTRIES));
      end
    end
  end

  assign out_valid     = v_r[HS];
  assign out_meta      = meta_r[HS];
  assign out_idx       = t_r[HS][IW-1:0];
  assign out_range_bad = bad_r[HS];
  assign out_big       = big_r[HS];

endmodule

// ===== src/pta_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, stall-enabled.
// Depends on pta_pkg.
module pta_div import pta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [REM_W-1:0] in_rem,
  input  logic [DEN_W-1:0] in_den,
  input  div_meta_t        in_meta,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output div_meta_t        out_meta
);

  logic             v   [QUO_W+1];
  logic [REM_W-1:0] rem [QUO_W+1];
  logic [DEN_W-1:0] den [QUO_W+1];
  logic [QUO_W-1:0] quo [QUO_W+1];
  div_meta_t        md  [QUO_W+1];

  assign v[0]   = in_valid;
  assign rem[0] = in_rem;
  assign den[0] = in_den;
  assign quo[0] = '0;
  assign md[0]  = in_meta;

  for (genvar i = 0; i < QUO_W; i++) begin : g_bit
    logic [REM_W-1:0] sh;
    logic             ge;
    assign sh = {rem[i][REM_W-2:0], 1'b0};
    assign ge = (sh >= REM_W'(den[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
      if (adv) begin
        rem[i+1] <= ge ? (sh - REM_W'(den[i])) : sh;
        den[i+1] <= den[i];
        quo[i+1] <= {quo[i][QUO_W-2:0], ge};
        md[i+1]  <= md[i];
      end
    end
  end

  assign out_valid = v[QUO_W];
  assign out_quo   = quo[QUO_W];
  assign out_meta  = md[QUO_W];

endmodule

// ===== src/prior_table_probability_adjust.sv =====
// Top level of the prior-table probability adjuster: config registers, table
// memories, multiply stages and result register. Depends on pta_pkg, pta_if,
// pta_ram, pta_index and pta_div.
//
//   channel  | role   | handshake            | payload
//   in_ch    | sink   | valid/ready          | cmd, feature_0..3, prediction, class_slot,
//            |        |                      | entry_index, entry_word
//   out_ch   | source | valid/ready          | adjusted, status
//   APB      | slave  | psel/penable, pready | paddr (4*i), pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; an accepted item
// passes 4 index stages (counting the one that takes the item), 1 memory read,
// 2 multiply stages, 17 divide stages and the result register. The divider's
// one-bit-per-stage chain makes up most of the pipeline depth.
// Reset is synchronous; tables hold no reset value and need no clearing pass.
// A stalled result freezes the whole pipeline; in_ch.ready is the pipeline's
// advance signal, so a new item enters whenever the result register can move.
module prior_table_probability_adjust import pta_pkg::*; #(
  parameter int PRIOR_ENTRIES = PRIOR_ENTRIES_DEF,
  parameter int DIMENSIONS    = DIMENSIONS_DEF,
  parameter int CLASSES       = CLASSES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  pta_in_if.sink         in_ch,
  pta_out_if.source      out_ch,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IW = $clog2(PRIOR_ENTRIES);
  localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;

  // ---------------- configuration registers
  logic [NDIM-1:0][FEAT_W-1:0] min_r;
  logic [NDIM-1:0][SPAN_W-1:0] span_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      for (int d = 0; d < NDIM; d++) begin
        span_r[d] <= SPAN_W'(1);
      end
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DIM0_MIN:  min_r[0]  <= pwdata[FEAT_W-1:0];
        REG_DIM1_MIN:  min_r[1]  <= pwdata[FEAT_W-1:0];
        REG_DIM2_MIN:  min_r[2]  <= pwdata[FEAT_W-1:0];
        REG_DIM3_MIN:  min_r[3]  <= pwdata[FEAT_W-1:0];
        REG_DIM0_SPAN: span_r[0] <= pwdata[SPAN_W-1:0];
        REG_DIM1_SPAN: span_r[1] <= pwdata[SPAN_W-1:0];
        REG_DIM2_SPAN: span_r[2] <= pwdata[SPAN_W-1:0];
        REG_DIM3_SPAN: span_r[3] <= pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DIM0_MIN:  prdata = 32'(min_r[0]);
      REG_DIM1_MIN:  prdata = 32'(min_r[1]);
      REG_DIM2_MIN:  prdata = 32'(min_r[2]);
      REG_DIM3_MIN:  prdata = 32'(min_r[3]);
      REG_DIM0_SPAN: prdata = 32'(span_r[0]);
      REG_DIM1_SPAN: prdata = 32'(span_r[1]);
      REG_DIM2_SPAN: prdata = 32'(span_r[2]);
      REG_DIM3_SPAN: prdata = 32'(span_r[3]);
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline advance
  logic out_valid_r;
  logic adv;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- index stages
  meta_t                       in_meta;
  logic [NDIM-1:0][FEAT_W-1:0] feat;
  logic                        iv;
  meta_t                       imeta;
  logic [IW-1:0]               iidx;
  logic                        ibad;
  logic                        ibig;

  assign in_meta.cmd  = in_ch.cmd;
  assign in_meta.slot = in_ch.class_slot;
  assign in_meta.eidx = in_ch.entry_index;
  assign in_meta.word = in_ch.entry_word;
  assign in_meta.p    = in_ch.prediction;
  assign feat         = {in_ch.feature_3, in_ch.feature_2, in_ch.feature_1, in_ch.feature_0};

  pta_index #(
    .PRIOR_ENTRIES (PRIOR_ENTRIES),
    .DIMENSIONS    (DIMENSIONS),
    .IW            (IW)
  ) u_index (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_ch.valid),
    .in_meta       (in_meta),
    .feat          (feat),
    .dmin          (min_r),
    .dspan         (span_r),
    .out_valid     (iv),
    .out_meta      (imeta),
    .out_idx       (iidx),
    .out_range_bad (ibad),
    .out_big       (ibig)
  );

  // ---------------- table access: writes and reads share one stage, so
  // program order between table writes and adjusts is kept without forwarding
  logic [16:0]       eidx_ext;
  logic [7:0]        slot_ext;
  logic              eidx_bad;
  logic              slot_bad;
  logic [1:0]        st_c;
  logic              prior_we;
  logic              odds_we;
  logic [PROB_W-1:0] q_rd;
  logic [ODDS_W-1:0] o_rd;

  assign eidx_ext = 17'(imeta.eidx);
  assign slot_ext = 8'(imeta.slot);
  assign eidx_bad = (eidx_ext >= 17'(PRIOR_ENTRIES));
  assign slot_bad = (slot_ext >= 8'(CLASSES));

  always_comb begin
    unique case (imeta.cmd)
      CMD_PRIOR_WR: st_c = eidx_bad ? ST_INDEX : ST_OK;
      CMD_ODDS_WR:  st_c = slot_bad ? ST_INDEX : ST_OK;
      CMD_ADJUST: begin
        if (ibad) begin
          st_c = ST_RANGE;
        end else if (ibig || slot_bad) begin
          st_c = ST_INDEX;
        end else begin
          st_c = ST_OK;
        end
      end
      default:      st_c = ST_OK;
    endcase
  end

  assign prior_we = adv && iv && (imeta.cmd == CMD_PRIOR_WR) && !eidx_bad;
  assign odds_we  = adv && iv && (imeta.cmd == CMD_ODDS_WR) && !slot_bad;

  pta_ram #(.W(PROB_W), .DEPTH(PRIOR_ENTRIES)) u_prior_ram (
    .clk   (clk),
    .we    (prior_we),
    .waddr (eidx_ext[IW-1:0]),
    .wdata (imeta.word[PROB_W-1:0]),
    .re    (adv),
    .raddr (iidx),
    .rdata (q_rd)
  );

  pta_ram #(.W(ODDS_W), .DEPTH(CLASSES)) u_odds_ram (
    .clk   (clk),
    .we    (odds_we),
    .waddr (slot_ext[CW-1:0]),
    .wdata (imeta.word),
    .re    (adv),
    .raddr (slot_ext[CW-1:0]),
    .rdata (o_rd)
  );

  // ---------------- arithmetic stages
  logic              v5_r, v6_r, v7_r;
  logic [PROB_W-1:0] p5_r;
  logic [1:0]        st5_r, st6_r, st7_r;
  logic              z5_r, z6_r, z7_r;
  logic [31:0]       pq6_r, pq7_r;
  logic [33:0]       m1_6_r;
  logic [ODDS_W-1:0] o6_r;
  logic [57:0]       rest7_r;
  logic [16:0]       one_p, one_q;

  assign one_p = 17'h10000 - 17'(p5_r);
  assign one_q = 17'h10000 - 17'(q_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v5_r <= iv;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
    if (adv) begin
      // stage 5: table data arrives
      p5_r   <= imeta.p;
      st5_r  <= st_c;
      z5_r   <= (imeta.cmd != CMD_ADJUST) || (st_c != ST_OK);
      // stage 6: p*q and (1-p)(1-q)
      pq6_r  <= 32'(p5_r) * 32'(q_rd);
      m1_6_r <= 34'(one_p) * 34'(one_q);
      o6_r   <= o_rd;
      st6_r  <= st5_r;
      z6_r   <= z5_r;
      // stage 7: times odds
      rest7_r <= 58'(m1_6_r) * 58'(o6_r);
      pq7_r   <= pq6_r;
      st7_r   <= st6_r;
      z7_r    <= z6_r;
    end
  end

  // stage 8 input: denominator and the divider's starting remainder
  logic [DEN_W-1:0] den_c;
  logic [REM_W-1:0] rem_c;
  logic             den_zero;
  div_meta_t        dm_c;

  assign den_c    = DEN_W'({pq7_r, 16'h0000}) + DEN_W'(rest7_r);
  assign rem_c    = REM_W'(pq7_r) << 15;
  assign den_zero = (pq7_r == '0) && (rest7_r == '0);

  always_comb begin
    dm_c.status   = st7_r;
    dm_c.zero_out = z7_r;
    if (!z7_r && den_zero) begin
      dm_c.status   = ST_ZERO_DEN;
      dm_c.zero_out = 1'b1;
    end
  end

  logic             dv;
  logic [QUO_W-1:0] quo;
  div_meta_t        dmeta;

  pta_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v7_r),
    .in_rem    (rem_c),
    .in_den    (den_c),
    .in_meta   (dm_c),
    .out_valid (dv),
    .out_quo   (quo),
    .out_meta  (dmeta)
  );

  // ---------------- result register; ratio of 1.0 saturates
  logic [PROB_W-1:0] adjusted_r;
  logic [1:0]        status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv;
    end
    if (adv) begin
      status_r <= dmeta.status;
      if (dmeta.zero_out) begin
        adjusted_r <= '0;
      end else if (quo[QUO_W-1]) begin
        adjusted_r <= '1;
      end else begin
        adjusted_r <= quo[PROB_W-1:0];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.adjusted = adjusted_r;
  assign out_ch.status   = status_r;

  // ---------------- checks
  a_wr_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (prior_we || odds_we) |-> adv)
    else $error("table written while pipeline stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK)) |-> (adjusted_r == '0))
    else $error("nonzero result with error status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v7_r) && $stable(dv)))
    else $error("pipeline moved during stall");

endmodule

// ===== verif/tb_prior_table_probability_adjust.sv =====
// Testbench for prior_table_probability_adjust: drives table writes and adjust items,
// predicts each result in a scoreboard class and compares. Depends on pta_pkg, pta_if.
`timescale 1ns / 100ps

module tb_prior_table_probability_adjust;
  import pta_pkg::*;

  // One input item as the sender sees it.
  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] feat [NDIM];
    logic [15:0] p;
    logic [2:0]  slot;
    logic [11:0] eidx;
    logic [23:0] word;
  } adj_item_t;

  typedef struct {
    logic [15:0] adjusted;
    logic [1:0]  status;
  } adj_result_t;

  // Mirrors the block's registers and tables and keeps the expected results in order.
  class adjust_scoreboard;
    logic [15:0] prior_mem [PRIOR_ENTRIES_DEF];
    logic [23:0] odds_mem  [CLASSES_DEF];
    logic [15:0] dim_min   [NDIM];
    logic [12:0] dim_span  [NDIM];
    adj_result_t expected_q [$];
    int errors;
    int checked;

    function new();
      foreach (dim_min[d]) begin
        dim_min[d]  = '0;
        dim_span[d] = 13'd1;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      if (idx < NDIM) dim_min[idx] = v[15:0];
      else dim_span[idx-NDIM] = v[12:0];
    endfunction

    // Range check and mixed-radix table index of an adjust.
    function logic [1:0] locate(adj_item_t it, output int unsigned idx);
      longint off;
      longint unsigned acc;
      longint unsigned fac;
      acc = 0;
      fac = 1;
      idx = 0;
      for (int d = 0; d < DIMENSIONS_DEF; d++) begin
        off = longint'($signed(it.feat[d])) - longint'($signed(dim_min[d]));
        if (off < 0 || off >= longint'(dim_span[d])) return ST_RANGE;
        acc += longint'(off) * fac;
        fac *= dim_span[d];
      end
      if (acc >= PRIOR_ENTRIES_DEF || it.slot >= CLASSES_DEF) return ST_INDEX;
      idx = int'(acc);
      return ST_OK;
    endfunction

    function void note_input(adj_item_t it);
      adj_result_t r;
      int unsigned idx;
      bit [63:0] p, q, o, num, rest, den, quo;
      r.adjusted = '0;
      r.status   = ST_OK;
      case (it.cmd)
        CMD_PRIOR_WR: begin
          if (it.eidx >= PRIOR_ENTRIES_DEF) r.status = ST_INDEX;
          else prior_mem[it.eidx] = it.word[15:0];
        end
        CMD_ODDS_WR: begin
          if (it.slot >= CLASSES_DEF) r.status = ST_INDEX;
          else odds_mem[it.slot] = it.word;
        end
        CMD_ADJUST: begin
          r.status = locate(it, idx);
          if (r.status == ST_OK) begin
            p    = 64'(it.p);
            q    = 64'(prior_mem[idx]);
            o    = 64'(odds_mem[it.slot]);
            num  = (p * q) << 16;
            rest = (64'd65536 - p) * (64'd65536 - q) * o;
            den  = num + rest;
            if (den == 0) begin
              r.status = ST_ZERO_DEN;
            end else begin
              quo = (num << 16) / den;
              r.adjusted = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
            end
          end
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(logic [15:0] adjusted, logic [1:0] status);
      adj_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result adjusted=%0d status=%0d", $time, adjusted, status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (adjusted !== e.adjusted) begin
        $display("%0t: adjusted mismatch: expected %0d, actual %0d", $time, e.adjusted, adjusted);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pta_in_if  in_ch ();
  pta_out_if out_ch ();

  prior_table_probability_adjust u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  adjust_scoreboard sb = new();

  bit idle_en = 1'b1;    // random gaps on both channels; cleared for the last phase
  bit written [PRIOR_ENTRIES_DEF];
  int written_q [$];     // prior entries holding data, for legal adjusts
  int items_sent = 0;
  int settings_done = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Result side: ready drops in random bursts while idling is on.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.adjusted, out_ch.status);
  end

  // Sender: called at a falling edge, returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no extra assignment.
  task automatic push_item(input adj_item_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.cmd         = it.cmd;
    in_ch.feature_0   = it.feat[0];
    in_ch.feature_1   = it.feat[1];
    in_ch.feature_2   = it.feat[2];
    in_ch.feature_3   = it.feat[3];
    in_ch.prediction  = it.p;
    in_ch.class_slot  = it.slot;
    in_ch.entry_index = it.eidx;
    in_ch.entry_word  = it.word;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 5'(idx * 4);
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Wait until every expected result is back, then let the pipeline empty.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] mins [NDIM], input logic [12:0] spans [NDIM]);
    drain();
    for (int d = 0; d < NDIM; d++) write_reg(REG_DIM0_MIN + d, {16'h0, mins[d]});
    for (int d = 0; d < NDIM; d++) write_reg(REG_DIM0_SPAN + d, {19'h0, spans[d]});
    settings_done++;
  endtask

  function automatic adj_item_t random_fields();
    adj_item_t it;
    it.cmd  = CMD_ADJUST;
    foreach (it.feat[d]) it.feat[d] = 16'($urandom);
    it.p    = 16'($urandom);
    it.slot = 3'($urandom);
    it.eidx = 12'($urandom);
    it.word = 24'($urandom);
    return it;
  endfunction

  function automatic adj_item_t prior_write(int idx, logic [23:0] word);
    adj_item_t it;
    it = random_fields();
    it.cmd  = CMD_PRIOR_WR;
    it.eidx = 12'(idx);
    it.word = word;
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_q = {written_q, idx};
    end
    return it;
  endfunction

  // Features that land on a table entry already written; 0 if none fits this setting.
  function automatic bit aim_at_written(ref adj_item_t it);
    int unsigned rem;
    int sp, f;
    bit fits;
    for (int tries = 0; tries < 8; tries++) begin
      rem  = written_q[$urandom_range(0, written_q.size() - 1)];
      fits = 1'b1;
      for (int d = 0; d < NDIM; d++) begin
        sp = sb.dim_span[d];
        if (sp == 0) return 1'b0;
        f = int'($signed(sb.dim_min[d])) + int'(rem % sp);
        rem = rem / sp;
        if (f > 32767) fits = 1'b0;
        it.feat[d] = 16'(f);
      end
      if (fits && rem == 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic adj_item_t random_item();
    adj_item_t it;
    int unsigned idx;
    int kind, d, f;
    it = random_fields();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      it = prior_write(($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 4095), it.word);
    end else if (kind < 15) begin
      it.cmd = CMD_ODDS_WR;
      if ($urandom_range(0, 7) == 0) it.word = '0;
    end else if (kind < 17) begin
      it.cmd = CMD_NONE;
    end else if (kind < 65) begin
      void'(aim_at_written(it));
      if ($urandom_range(0, 15) == 0) it.p = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
    end else if (kind < 92) begin
      // in-range offsets everywhere; for kind < 80, one dimension pushed just outside for range errors
      for (d = 0; d < NDIM; d++) begin
        f = int'($signed(sb.dim_min[d]))
            + ((sb.dim_span[d] == 0) ? 0 : $urandom_range(0, sb.dim_span[d] - 1));
        it.feat[d] = 16'(f);
      end
      if (kind < 80) begin
        d = $urandom_range(0, NDIM - 1);
        f = int'($signed(sb.dim_min[d]));
        if (f > -32768 && $urandom_range(0, 1) != 0) it.feat[d] = 16'(f - 1);
        else if (f + int'(sb.dim_span[d]) <= 32767) it.feat[d] = 16'(f + sb.dim_span[d]);
      end
    end
    // never read a prior entry that holds nothing
    if (it.cmd == CMD_ADJUST && sb.locate(it, idx) == ST_OK && !written[idx])
      it = prior_write(int'(idx), it.word);
    return it;
  endfunction

  function automatic adj_item_t adjust_item(logic [15:0] f0, logic [15:0] p, logic [2:0] slot);
    adj_item_t it;
    it = random_fields();
    it.feat[0] = f0;
    it.feat[1] = '0;
    it.feat[2] = '0;
    it.feat[3] = '0;
    it.p    = p;
    it.slot = slot;
    return it;
  endfunction

  task automatic run_random(input int count);
    repeat (count) push_item(random_item());
  endtask

  initial begin
    logic [15:0] mins  [NDIM];
    logic [12:0] spans [NDIM];
    adj_item_t it;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NONE;
    in_ch.feature_0 = '0;
    in_ch.feature_1 = '0;
    in_ch.feature_2 = '0;
    in_ch.feature_3 = '0;
    in_ch.prediction = '0;
    in_ch.class_slot = '0;
    in_ch.entry_index = '0;
    in_ch.entry_word = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part under reset registers: only all-zero features are in range.
    // Odds: slot 0 zero (zero denominator / full ratio), slot 1 one, slot 7 all ones.
    for (int s = 0; s < CLASSES_DEF; s++) begin
      it = random_fields();
      it.cmd  = CMD_ODDS_WR;
      it.slot = 3'(s);
      it.word = (s == 0) ? 24'h0 : (s == 1) ? 24'h010000 : (s == 7) ? 24'hFFFFFF : it.word;
      push_item(it);
    end
    push_item(prior_write(0, 24'h0));
    push_item(prior_write(4095, 24'hFFFFFF));
    push_item(adjust_item(16'h0, 16'h0, 3'd0));       // p and q zero, no odds: zero denominator
    push_item(adjust_item(16'h0, 16'hFFFF, 3'd1));    // q zero: result zero
    push_item(adjust_item(16'h0, 16'h8000, 3'd7));
    push_item(prior_write(0, 24'hAB8000));            // read right behind the write
    push_item(adjust_item(16'h0, 16'h8000, 3'd0));    // no odds: full ratio saturates
    push_item(adjust_item(16'h0, 16'hFFFF, 3'd7));
    push_item(adjust_item(16'h0, 16'h0001, 3'd1));
    push_item(adjust_item(16'h0001, 16'h1234, 3'd1)); // out of range above
    push_item(adjust_item(16'hFFFF, 16'h1234, 3'd1)); // out of range below
    push_item(adjust_item(16'h8000, 16'h1234, 3'd2));
    push_item(adjust_item(16'h7FFF, 16'h1234, 3'd2));
    it = random_fields();
    it.cmd = CMD_NONE;
    push_item(it);
    run_random(120);

    // Extreme minimums, one wide dimension.
    mins  = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFB};
    spans = '{13'd4096, 13'd1, 13'd1, 13'd1};
    apply_setting(mins, spans);
    for (int i = 0; i < 8; i++) push_item(prior_write($urandom_range(0, 4095), 24'($urandom)));
    run_random(250);

    // Product of spans beyond the table: index errors reachable.
    mins  = '{16'hFFFD, 16'd10, 16'hFFEC, 16'd7};
    spans = '{13'd16, 13'd16, 13'd16, 13'd16};
    apply_setting(mins, spans);
    run_random(250);

    // Widest spans with the last one zero: every adjust is out of range.
    mins  = '{16'd100, 16'hFF9C, 16'h0, 16'h0};
    spans = '{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h0};
    apply_setting(mins, spans);
    run_random(60);

    // Last phase runs with no gaps on either side.
    mins  = '{16'h7FFF, 16'h8000, 16'd1000, 16'hFC18};
    spans = '{13'd1, 13'd4096, 13'd2, 13'd1};
    apply_setting(mins, spans);
    idle_en = 1'b0;
    for (int i = 0; i < 16; i++) push_item(prior_write($urandom_range(0, 4095), 24'($urandom)));
    run_random(250);

    drain();
    $display("covered %0d items over %0d register settings, %0d results compared",
             items_sent, settings_done + 1, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
